@@ rtl/wcba_pkg.sv @@
package wcba_pkg;

   // WAH word layout
   localparam logic [31:0] W_FILL = 32'h8000_0000;
   localparam logic [31:0] W_ONE  = 32'h4000_0000;
   localparam logic [31:0] W_LIT  = 32'h7fff_ffff;
   localparam logic [31:0] W_CNT  = 32'h3fff_ffff;

   // fill kind tags in bits 31..30
   localparam logic [1:0] TAG_ZERO_FILL = 2'b10;

   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_COUNT_W = $clog2(Q_DEPTH + 1);

   // input action codes
   typedef enum logic [1:0] {
      ACT_WORD_A = 2'd0,
      ACT_WORD_B = 2'd1,
      ACT_END    = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CMD_WORD_A,
      CMD_WORD_B,
      CMD_END,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  word;
   } cmd_type;

endpackage

@@ rtl/wcba_front.sv @@
module wcba_front (
   input  logic                   req_valid,
   input  logic [1:0]             req_action,
   input  logic [31:0]            req_in_word,
   input  logic                   q_full,
   output logic                   req_stall,
   output logic                   push,
   output wcba_pkg::cmd_type      push_cmd
);
   import wcba_pkg::*;

   action_type act;

   assign act       = action_type'(req_action);
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // classify the incoming request by its action code
   always_comb begin
      push_cmd.word = req_in_word;
      unique case (act)
         ACT_WORD_A: push_cmd.kind = CMD_WORD_A;
         ACT_WORD_B: push_cmd.kind = CMD_WORD_B;
         ACT_END:    push_cmd.kind = CMD_END;
         default:    push_cmd.kind = CMD_NOP;
      endcase
   end

endmodule

@@ rtl/wcba_queue.sv @@
module wcba_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wcba_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output logic                 q_full,
   output logic                 q_empty,
   output wcba_pkg::cmd_type    head_cmd
);
   import wcba_pkg::*;

   cmd_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_COUNT_W-1:0] count_ff, count_in;

   assign q_full   = (count_ff == Q_COUNT_W'(Q_DEPTH));
   assign q_empty  = (count_ff == '0);
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/wcba_back.sv @@
module wcba_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  wcba_pkg::cmd_type    head_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_word_valid,
   output logic [31:0]          rsp_out_word,
   output logic                 rsp_last,
   output logic                 rsp_need_a,
   output logic                 rsp_need_b,
   output logic                 rsp_error
);
   import wcba_pkg::*;

   logic [31:0] slot_a_word_ff, slot_a_word_in;
   logic        slot_a_full_ff, slot_a_full_in;
   logic [31:0] slot_b_word_ff, slot_b_word_in;
   logic        slot_b_full_ff, slot_b_full_in;
   logic [31:0] pend_word_ff, pend_word_in;
   logic        pend_full_ff, pend_full_in;

   logic        rsp_valid_ff;
   logic        word_valid_ff, word_valid_in;
   logic [31:0] out_word_ff, out_word_in;
   logic        last_ff, last_in;
   logic        error_ff, error_in;

   logic        advance;

   assign advance = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign pop     = advance;

   always_comb begin
      logic        merge;
      logic [29:0] ca, cb, n;
      logic [30:0] va, vb, val;
      logic [30:0] sum;

      slot_a_word_in = slot_a_word_ff;
      slot_a_full_in = slot_a_full_ff;
      slot_b_word_in = slot_b_word_ff;
      slot_b_full_in = slot_b_full_ff;
      pend_word_in   = pend_word_ff;
      pend_full_in   = pend_full_ff;
      word_valid_in  = 1'b0;
      out_word_in    = '0;
      last_in        = 1'b0;
      error_in       = 1'b0;
      merge          = 1'b0;

      // load the slot (error if already full); merge once both are full; END flushes
      unique case (head_cmd.kind)
         CMD_WORD_A: begin
            if (slot_a_full_ff) begin
               error_in = 1'b1;
            end else begin
               slot_a_word_in = head_cmd.word;
               slot_a_full_in = 1'b1;
               merge          = slot_b_full_ff;
            end
         end
         CMD_WORD_B: begin
            if (slot_b_full_ff) begin
               error_in = 1'b1;
            end else begin
               slot_b_word_in = head_cmd.word;
               slot_b_full_in = 1'b1;
               merge          = slot_a_full_ff;
            end
         end
         CMD_END: begin
            last_in = 1'b1;
            if (pend_full_ff && pend_word_ff[31:30] != TAG_ZERO_FILL) begin
               word_valid_in = 1'b1;
               out_word_in   = pend_word_ff;
            end
            slot_a_full_in = 1'b0;
            slot_b_full_in = 1'b0;
            pend_full_in   = 1'b0;
            slot_a_word_in = '0;
            slot_b_word_in = '0;
            pend_word_in   = '0;
         end
         default: begin
         end
      endcase

      // expand both words to value and run count
      if (slot_a_word_in[31]) begin
         va = {31{slot_a_word_in[30]}};
         ca = slot_a_word_in[29:0];
      end else begin
         va = slot_a_word_in[30:0];
         ca = 30'd1;
      end
      if (slot_b_word_in[31]) begin
         vb = {31{slot_b_word_in[30]}};
         cb = slot_b_word_in[29:0];
      end else begin
         vb = slot_b_word_in[30:0];
         cb = 30'd1;
      end
      val = va & vb;
      n   = (ca <= cb) ? ca : cb;
      sum = {1'b0, pend_word_ff[29:0]} + {1'b0, n};

      if (merge) begin
         // consume covered words, shorten the longer fill
         if (cb >= ca) slot_a_full_in = 1'b0;
         else          slot_a_word_in = slot_a_word_in - {2'b00, cb};
         if (ca >= cb) slot_b_full_in = 1'b0;
         else          slot_b_word_in = slot_b_word_in - {2'b00, ca};

         if (n != '0) begin
            pend_full_in = 1'b1;
            if (val == '0 || val == W_LIT[30:0]) begin
               if (pend_full_ff && pend_word_ff[31] && pend_word_ff[30] == val[30]) begin
                  // same fill kind: grow the pending run, split at max count
                  if (sum[30]) begin
                     word_valid_in = 1'b1;
                     out_word_in   = pend_word_ff | W_CNT;
                     sum           = sum - W_CNT[30:0];
                  end
                  pend_word_in = {1'b1, val[30], sum[29:0]};
               end else begin
                  word_valid_in = pend_full_ff;
                  out_word_in   = pend_full_ff ? pend_word_ff : '0;
                  pend_word_in  = {1'b1, val[30], n};
               end
            end else begin
               word_valid_in = pend_full_ff;
               out_word_in   = pend_full_ff ? pend_word_ff : '0;
               pend_word_in  = {1'b0, val};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_a_full_ff <= 1'b0;
         slot_b_full_ff <= 1'b0;
         pend_full_ff   <= 1'b0;
         slot_a_word_ff <= '0;
         slot_b_word_ff <= '0;
         pend_word_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            slot_a_full_ff <= slot_a_full_in;
            slot_b_full_ff <= slot_b_full_in;
            pend_full_ff   <= pend_full_in;
            slot_a_word_ff <= slot_a_word_in;
            slot_b_word_ff <= slot_b_word_in;
            pend_word_ff   <= pend_word_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // result payload, held while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         word_valid_ff <= word_valid_in;
         out_word_ff   <= out_word_in;
         last_ff       <= last_in;
         error_ff      <= error_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_valid = word_valid_ff;
   assign rsp_out_word   = out_word_ff;
   assign rsp_last       = last_ff;
   assign rsp_error      = error_ff;
   // slot status after the item
   assign rsp_need_a     = !slot_a_full_ff;
   assign rsp_need_b     = !slot_b_full_ff;

endmodule

@@ rtl/wah_compressed_bitmap_and.sv @@
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_action, req_in_word
// rsp_      out        rsp_valid/rsp_stall  rsp_word_valid, rsp_out_word, rsp_last,
//                                           rsp_need_a, rsp_need_b, rsp_error
//
// One word per cycle sustained while nothing stalls; a word accepted on req_ is
// first written into the queue, and the merge unit works straight off the queue
// head, loading the output register that drives rsp_ as it pops the word.
// The merge unit does the whole step (compare, subtract, add) combinationally.
// Reset is synchronous: it empties the queue, both slots and the pending word.
// A stalled result holds in the output register; the two-entry queue absorbs
// words meanwhile, and req_stall rises only once the queue is full.
module wah_compressed_bitmap_and (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_in_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_word_valid,
   output logic [31:0] rsp_out_word,
   output logic        rsp_last,
   output logic        rsp_need_a,
   output logic        rsp_need_b,
   output logic        rsp_error
);
   import wcba_pkg::*;

   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;

   // front: decode the action into a command and push it into the queue
   wcba_front u_front (
      .req_valid   (req_valid),
      .req_action  (req_action),
      .req_in_word (req_in_word),
      .q_full      (q_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decoupling queue between decode and merge
   wcba_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_full   (q_full),
      .q_empty  (q_empty),
      .head_cmd (head_cmd)
   );

   // back: slots, merge step, pending word and the output register
   wcba_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_valid (rsp_word_valid),
      .rsp_out_word   (rsp_out_word),
      .rsp_last       (rsp_last),
      .rsp_need_a     (rsp_need_a),
      .rsp_need_b     (rsp_need_b),
      .rsp_error      (rsp_error)
   );

endmodule
